// ===== design/ssfg_pkg.sv =====
// Shared constants, types and the gap sequence for the fixed-gap Shell sort unit.
// Depends on nothing; used by ssfg_mem, ssfg_ctrl and shell_sort_fixed_gaps_unit.
package ssfg_pkg;

  localparam int unsigned Depth    = 64;
  localparam int unsigned AddrW    = $clog2(Depth);
  localparam int unsigned CntW     = $clog2(Depth + 1);
  localparam int unsigned DataW    = 32;
  localparam int unsigned GapCount = 5;
  localparam int unsigned GapIdxW  = $clog2(GapCount);

  localparam logic [GapIdxW-1:0] LastGap = GapIdxW'(GapCount - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_LOADX,
    ST_CMP,
    ST_PUT,
    ST_EMIT_RD,
    ST_EMIT_LD
  } state_e;

  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [DataW-1:0] wdata;
    logic [AddrW-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic             load;
    logic [DataW-1:0] value;
    logic             last;
    logic             ovf;
  } emit_t;

  function automatic logic [CntW-1:0] gap_of(input logic [GapIdxW-1:0] k);
    logic [CntW-1:0] g;
    case (k)
      GapIdxW'(0): g = CntW'(9);
      GapIdxW'(1): g = CntW'(5);
      GapIdxW'(2): g = CntW'(3);
      GapIdxW'(3): g = CntW'(2);
      default:     g = CntW'(1);
    endcase
    return g;
  endfunction

endpackage

// ===== design/ssfg_mem.sv =====
// Element store: one write port and one read port with registered read data.
// Depends on ssfg_pkg for the depth, widths and request struct.
module ssfg_mem (
  input  logic                         clk_i,
  input  ssfg_pkg::mem_req_t           req_i,
  output logic [ssfg_pkg::DataW-1:0]   rdata_o
);

  logic [ssfg_pkg::DataW-1:0] mem [ssfg_pkg::Depth];
  logic [ssfg_pkg::DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/ssfg_ctrl.sv =====
// Sequencer for load, gapped insertion passes and emit, with the shared compare unit.
// Depends on ssfg_pkg; drives the element store and the output register of the top level.
module ssfg_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [ssfg_pkg::DataW-1:0]   value_i,
  input  logic                         last_i,
  output ssfg_pkg::mem_req_t           mem_req_o,
  input  logic [ssfg_pkg::DataW-1:0]   rdata_i,
  input  logic                         out_free_i,
  output ssfg_pkg::emit_t              emit_o
);

  ssfg_pkg::state_e                state_q, state_d;
  logic [ssfg_pkg::CntW-1:0]       count_q, count_d;
  logic                            ovf_q, ovf_d;
  logic [ssfg_pkg::GapIdxW-1:0]    k_q, k_d;
  logic [ssfg_pkg::CntW-1:0]       i_q, i_d;
  logic [ssfg_pkg::AddrW-1:0]      p_q, p_d;
  logic [ssfg_pkg::DataW-1:0]      x_q, x_d;
  logic [ssfg_pkg::AddrW-1:0]      e_q, e_d;

  logic                            accept;
  logic [ssfg_pkg::CntW-1:0]       gap;
  logic [ssfg_pkg::AddrW-1:0]      gap_a;
  logic [ssfg_pkg::AddrW-1:0]      p_next;
  logic                            cont;
  logic                            less;
  logic                            i_in_range;
  logic                            e_last;
  logic                            room;

  assign accept     = in_valid_i && in_ready_o;
  assign gap        = ssfg_pkg::gap_of(k_q);
  assign gap_a      = gap[ssfg_pkg::AddrW-1:0];
  assign p_next     = p_q - gap_a;
  assign cont       = ssfg_pkg::CntW'(p_next) >= gap;
  assign less       = $signed(x_q) < $signed(rdata_i);
  assign i_in_range = i_q < count_q;
  assign e_last     = (ssfg_pkg::CntW'(e_q) + ssfg_pkg::CntW'(1)) == count_q;
  assign room       = count_q < ssfg_pkg::CntW'(ssfg_pkg::Depth);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ssfg_pkg::ST_IDLE: begin
        if (accept && last_i) state_d = ssfg_pkg::ST_SETUP;
      end
      ssfg_pkg::ST_SETUP: begin
        if (i_in_range) begin
          state_d = ssfg_pkg::ST_LOADX;
        end else if (k_q == ssfg_pkg::LastGap) begin
          state_d = ssfg_pkg::ST_EMIT_RD;
        end
      end
      ssfg_pkg::ST_LOADX: state_d = ssfg_pkg::ST_CMP;
      ssfg_pkg::ST_CMP: begin
        if (!less) begin
          state_d = ssfg_pkg::ST_SETUP;
        end else if (!cont) begin
          state_d = ssfg_pkg::ST_PUT;
        end
      end
      ssfg_pkg::ST_PUT:     state_d = ssfg_pkg::ST_SETUP;
      ssfg_pkg::ST_EMIT_RD: state_d = ssfg_pkg::ST_EMIT_LD;
      ssfg_pkg::ST_EMIT_LD: begin
        if (out_free_i) state_d = e_last ? ssfg_pkg::ST_IDLE : ssfg_pkg::ST_EMIT_RD;
      end
      default: state_d = ssfg_pkg::ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    in_ready_o = 1'b0;
    mem_req_o  = '0;
    emit_o     = '0;
    count_d    = count_q;
    ovf_d      = ovf_q;
    k_d        = k_q;
    i_d        = i_q;
    p_d        = p_q;
    x_d        = x_q;
    e_d        = e_q;
    case (state_q)
      ssfg_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (accept) begin
          if (room) begin
            mem_req_o.we    = 1'b1;
            mem_req_o.waddr = count_q[ssfg_pkg::AddrW-1:0];
            mem_req_o.wdata = value_i;
            count_d         = count_q + ssfg_pkg::CntW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (last_i) begin
            k_d = '0;
            i_d = ssfg_pkg::gap_of('0);
          end
        end
      end
      ssfg_pkg::ST_SETUP: begin
        if (i_in_range) begin
          mem_req_o.raddr = i_q[ssfg_pkg::AddrW-1:0];
        end else if (k_q == ssfg_pkg::LastGap) begin
          e_d = '0;
        end else begin
          k_d = k_q + ssfg_pkg::GapIdxW'(1);
          i_d = ssfg_pkg::gap_of(k_q + ssfg_pkg::GapIdxW'(1));
        end
      end
      ssfg_pkg::ST_LOADX: begin
        x_d             = rdata_i;
        p_d             = i_q[ssfg_pkg::AddrW-1:0];
        mem_req_o.raddr = i_q[ssfg_pkg::AddrW-1:0] - gap_a;
      end
      ssfg_pkg::ST_CMP: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = p_q;
        if (less) begin
          mem_req_o.wdata = rdata_i;
          p_d             = p_next;
          mem_req_o.raddr = p_next - gap_a;
        end else begin
          mem_req_o.wdata = x_q;
          i_d             = i_q + ssfg_pkg::CntW'(1);
        end
      end
      ssfg_pkg::ST_PUT: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = p_q;
        mem_req_o.wdata = x_q;
        i_d             = i_q + ssfg_pkg::CntW'(1);
      end
      ssfg_pkg::ST_EMIT_RD: begin
        mem_req_o.raddr = e_q;
      end
      ssfg_pkg::ST_EMIT_LD: begin
        mem_req_o.raddr = e_q;
        if (out_free_i) begin
          emit_o.load  = 1'b1;
          emit_o.value = rdata_i;
          emit_o.last  = e_last;
          emit_o.ovf   = ovf_q;
          if (e_last) begin
            count_d = '0;
            ovf_d   = 1'b0;
          end else begin
            e_d = e_q + ssfg_pkg::AddrW'(1);
          end
        end
      end
      default: begin
        count_d = '0;
        ovf_d   = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ssfg_pkg::ST_IDLE;
      count_q <= '0;
      ovf_q   <= 1'b0;
      k_q     <= '0;
      i_q     <= '0;
      p_q     <= '0;
      e_q     <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
      k_q     <= k_d;
      i_q     <= i_d;
      p_q     <= p_d;
      e_q     <= e_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
  end

`ifndef SYNTH
  a_cmp_pos_above_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ssfg_pkg::ST_CMP |-> ssfg_pkg::CntW'(p_q) >= gap)
    else $error("compare position below current gap");

  a_load_needs_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_o.load |-> out_free_i)
    else $error("result loaded into occupied output register");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= ssfg_pkg::CntW'(ssfg_pkg::Depth))
    else $error("element count beyond store depth");

  a_final_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_o.load && emit_o.last) |=> (count_q == '0 && !ovf_q && state_q == ssfg_pkg::ST_IDLE))
    else $error("run state not cleared after final result");

  a_sort_write_in_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_req_o.we && state_q != ssfg_pkg::ST_IDLE)
      |-> ssfg_pkg::CntW'(mem_req_o.waddr) < count_q)
    else $error("sort write outside stored set");
`endif

endmodule

// ===== design/shell_sort_fixed_gaps_unit.sv =====
// Top level of the fixed-gap Shell sort unit: store, sequencer and output register.
// Depends on ssfg_pkg, ssfg_mem and ssfg_ctrl.
//
//   channel | valid/ready            | payload
//   in      | in_valid_i/in_ready_o  | value_i, last_i
//   out     | out_valid_o/out_ready_i| sorted_value_o, last_res_o, overflow_o
//
// Loading takes one item per cycle. After the last item, each gapped pass takes each
// position from the gap up to the set size via setup, load, compare and put steps,
// then closes, all on the single store read port; emitting reads each result, then
// loads it. Input is held off from the last item until the final result is loaded.
// Output stalls hold the sequencer in its emit step. Reset clears all control state.
module shell_sort_fixed_gaps_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [31:0]           value_i,
  input  logic                         last_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [31:0]           sorted_value_o,
  output logic                         last_res_o,
  output logic                         overflow_o
);

  ssfg_pkg::mem_req_t               mem_req;
  logic [ssfg_pkg::DataW-1:0]       rdata;
  ssfg_pkg::emit_t                  emit;
  logic                             out_free;

  logic                             out_valid_q, out_valid_d;
  logic [ssfg_pkg::DataW-1:0]       out_value_q;
  logic                             out_last_q;
  logic                             out_ovf_q;

  assign out_free = !out_valid_q || out_ready_i;

  ssfg_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  ssfg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .value_i    (value_i),
    .last_i     (last_i),
    .mem_req_o  (mem_req),
    .rdata_i    (rdata),
    .out_free_i (out_free),
    .emit_o     (emit)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit.load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit.load) begin
      out_value_q <= emit.value;
      out_last_q  <= emit.last;
      out_ovf_q   <= emit.ovf;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sorted_value_o = out_value_q;
  assign last_res_o     = out_last_q;
  assign overflow_o     = out_ovf_q;

endmodule
